// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level of the time-of-flight weight block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define TOFW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Check that a condition implies another in the same cycle.
`define TOFW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Check that a condition implies another in the next cycle.
`define TOFW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- hw/rtl/tofw_pkg.sv -----
// Shared constants, mass tables and status type of the time-of-flight weight block.
`default_nettype none

package tofw_pkg;

  localparam int unsigned NumHyp = 8;
  localparam int unsigned KW     = (NumHyp > 1) ? $clog2(NumHyp) : 1;
  localparam int unsigned RAW_W  = 33;
  localparam int unsigned SUM_W  = RAW_W + KW;
  localparam int unsigned DVD_W  = 64;
  localparam int unsigned DVS_W  = (SUM_W > 32) ? SUM_W : 32;
  localparam int unsigned POW_W  = 4;
  localparam logic [POW_W-1:0] PowReset = 4'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Squared masses, Q32.32.
  function automatic logic [35:0] mass_sq(input logic [2:0] hyp);
    logic [35:0] v;
    unique case (hyp)
      3'd0: v = 36'd3781143081;
      3'd1: v = 36'd83667609;
      3'd2: v = 36'd1046781316;
      3'd3: v = 36'd1089;
      3'd4: v = 36'd15117686116;
      3'd5: v = 36'd33899806161;
      3'd6: v = 36'd33899437924;
      default: v = 36'd59704479025;
    endcase
    return v;
  endfunction

  // Helium hypotheses carry charge two.
  function automatic logic double_charge(input logic [2:0] hyp);
    return (hyp == 3'd6) || (hyp == 3'd7);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tofw_sqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none

module tofw_sqrt (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [63:0]          rad_i,
  output logic      [31:0]          root_o,
  output tofw_pkg::unit_sts_t       sts_o
);
  import tofw_pkg::*;

  logic [63:0] rad_q, rad_d;
  logic [35:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [35:0] sh, trial;

  assign sh    = {rem_q[33:0], rad_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[61:0], 2'b00};
      if (sh >= trial) begin
        rem_d  = sh - trial;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = sh;
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign sts_o  = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ----- hw/rtl/tofw_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module tofw_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [tofw_pkg::DVD_W-1:0]    dividend_i,
  input  wire logic [tofw_pkg::DVS_W-1:0]    divisor_i,
  output logic      [tofw_pkg::DVD_W-1:0]    quot_o,
  output tofw_pkg::unit_sts_t                sts_o
);
  import tofw_pkg::*;

  localparam int unsigned CW = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DVS_W:0]   sh;

  assign sh = {rem_q, dvd_q[DVD_W-1]};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, dvs_q}) begin
        rem_d = DVS_W'(sh - {1'b0, dvs_q});
        dvd_d = {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = DVS_W'(sh);
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign quot_o = dvd_q;
  assign sts_o  = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ----- hw/rtl/tof_mass_hypothesis_weights.sv -----
// Top level of the time-of-flight mass hypothesis weight block.
//
// Input channel s_axis_*: one transaction carries one track (rigidity and
// the near and far beta values with their present flags). Output channel
// m_axis_*: eight transactions per track, one per hypothesis in order
// p, pi, K, e, d, t, He3, He4, the eighth with tlast high.
// cfg_wr_en_i/cfg_wr_data_i write model_power (reset value 2); write it
// only while the block is idle.
// A track is worked on alone: s_axis_tready_o is high only while idle.
// Per hypothesis a serial square root and a serial division form the
// expected beta; per present detector a minimum scan over the
// hypotheses, then per hypothesis a division and model_power multiply
// steps form raw weights; each result then needs one division per
// present detector. All these divisions share one serial divider.
// First result appears after all raw weights are done.
// Reset clears the sequencer and output valid; no store needs clearing.
// When the receiver stalls the output register holds its transaction and
// the sequencer waits before loading the next one.
`default_nettype none

module tof_mass_hypothesis_weights (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // rigidity[31:0], beta_near[49:32], near_present[50], beta_far[68:51],
  // far_present[69], zero fill
  input  wire logic [71:0] s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // hypothesis[2:0], weight_near[19:3], near_weight_valid[20],
  // weight_far[37:21], far_weight_valid[38], zero fill
  output logic      [39:0] m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [3:0]  cfg_wr_data_i
);
  import tofw_pkg::*;
  `include "assert_macros.svh"

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PM    = 4'd1;
  localparam logic [3:0] ST_SQ    = 4'd2;
  localparam logic [3:0] ST_SQRT  = 4'd3;
  localparam logic [3:0] ST_BHDIV = 4'd4;
  localparam logic [3:0] ST_DET   = 4'd5;
  localparam logic [3:0] ST_DMIN  = 4'd6;
  localparam logic [3:0] ST_RDIV  = 4'd7;
  localparam logic [3:0] ST_POW   = 4'd8;
  localparam logic [3:0] ST_WDIV  = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;

  localparam logic [KW-1:0] KLast = KW'(NumHyp - 1);

  logic [3:0]       state_q, state_d;
  logic             started_q, started_d;
  logic [KW-1:0]    k_q, k_d;
  logic             det_q, det_d;
  logic [POW_W-1:0] power_q;
  logic [31:0]      mag_q, mag_d;
  logic [17:0]      beta_q [2];
  logic [1:0]       on_q;
  logic [31:0]      pm_q, pm_d;
  logic [63:0]      sqv_q, sqv_d;
  logic [31:0]      e_q, e_d;
  logic [16:0]      bh_q [NumHyp];
  logic [17:0]      dmin_q, dmin_d;
  logic [24:0]      r_q, r_d;
  logic [RAW_W-1:0] x_q, x_d;
  logic [POW_W-1:0] pcnt_q, pcnt_d;
  logic [RAW_W-1:0] raw_q [2][NumHyp];
  logic [SUM_W-1:0] sum_q [2];
  logic [16:0]      wgt_q [2];
  logic             bh_we, raw_we, sum_clr, wgt_we;
  logic [16:0]      wgt_val;
  logic [39:0]      out_data_q;
  logic             out_last_q, out_valid_q, out_load;

  logic             sqrt_start, div_start;
  logic [31:0]      sqrt_root;
  unit_sts_t        sqrt_sts, div_sts;
  logic [DVD_W-1:0] div_dvd, div_quot;
  logic [DVS_W-1:0] div_dvs;

  logic [2:0]       hyp;
  logic [32:0]      pm_raw;
  logic [17:0]      hv, diff_abs, diff;
  logic [57:0]      prod;
  logic             in_acc;

  assign hyp     = 3'(k_q);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign pm_raw  = double_charge(hyp) ? {mag_q, 1'b0} : {1'b0, mag_q};
  assign hv      = {1'b0, bh_q[k_q]};
  assign diff_abs = (beta_q[det_q] > hv) ? (beta_q[det_q] - hv) : (hv - beta_q[det_q]);
  assign diff    = (diff_abs == '0) ? 18'd1 : diff_abs;
  assign prod    = x_q * r_q;

  // Operand select for the shared divider.
  always_comb begin
    unique case (state_q)
      ST_BHDIV: begin
        div_dvd = {16'd0, pm_q, 16'd0};
        div_dvs = DVS_W'(e_q);
      end
      ST_RDIV: begin
        div_dvd = DVD_W'({dmin_q, 24'd0});
        div_dvs = DVS_W'(diff);
      end
      default: begin
        div_dvd = DVD_W'({raw_q[det_q][k_q], 16'd0});
        div_dvs = DVS_W'(sum_q[det_q]);
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    started_d  = started_q;
    k_d        = k_q;
    det_d      = det_q;
    mag_d      = mag_q;
    pm_d       = pm_q;
    sqv_d      = sqv_q;
    e_d        = e_q;
    dmin_d     = dmin_q;
    r_d        = r_q;
    x_d        = x_q;
    pcnt_d     = pcnt_q;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    bh_we      = 1'b0;
    raw_we     = 1'b0;
    sum_clr    = 1'b0;
    wgt_we     = 1'b0;
    wgt_val    = div_quot[16:0];
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mag_d   = s_axis_tdata_i[31] ? (32'd0 - s_axis_tdata_i[31:0])
                                       : s_axis_tdata_i[31:0];
          k_d     = '0;
          state_d = ST_PM;
        end
      end
      ST_PM: begin
        // Saturate momentum at 2^31.
        pm_d    = (pm_raw > 33'h080000000) ? 32'h80000000 : pm_raw[31:0];
        state_d = ST_SQ;
      end
      ST_SQ: begin
        sqv_d   = (pm_q * pm_q) + 64'(mass_sq(hyp));
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (!started_q) begin
          sqrt_start = 1'b1;
          started_d  = 1'b1;
        end else if (sqrt_sts.done) begin
          e_d       = sqrt_root;
          started_d = 1'b0;
          state_d   = ST_BHDIV;
        end
      end
      ST_BHDIV: begin
        if (!started_q) begin
          div_start = 1'b1;
          started_d = 1'b1;
        end else if (div_sts.done) begin
          bh_we     = 1'b1;
          started_d = 1'b0;
          if (k_q == KLast) begin
            k_d     = '0;
            det_d   = 1'b0;
            state_d = ST_DET;
          end else begin
            k_d     = k_q + KW'(1);
            state_d = ST_PM;
          end
        end
      end
      ST_DET: begin
        sum_clr = 1'b1;
        k_d     = '0;
        dmin_d  = '1;
        if (on_q[det_q]) begin
          state_d = ST_DMIN;
        end else if (!det_q) begin
          det_d = 1'b1;
        end else begin
          det_d   = 1'b0;
          state_d = ST_WDIV;
        end
      end
      ST_DMIN: begin
        if (diff < dmin_q) dmin_d = diff;
        if (k_q == KLast) begin
          k_d     = '0;
          state_d = ST_RDIV;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ST_RDIV: begin
        if (!started_q) begin
          div_start = 1'b1;
          started_d = 1'b1;
        end else if (div_sts.done) begin
          r_d       = div_quot[24:0];
          x_d       = RAW_W'(64'h1_0000_0000);
          pcnt_d    = '0;
          started_d = 1'b0;
          state_d   = ST_POW;
        end
      end
      ST_POW: begin
        if (pcnt_q == power_q) begin
          raw_we = 1'b1;
          if (k_q != KLast) begin
            k_d     = k_q + KW'(1);
            state_d = ST_RDIV;
          end else if (!det_q) begin
            det_d   = 1'b1;
            state_d = ST_DET;
          end else begin
            k_d     = '0;
            det_d   = 1'b0;
            state_d = ST_WDIV;
          end
        end else begin
          x_d    = prod[56:24];
          pcnt_d = pcnt_q + POW_W'(1);
        end
      end
      ST_WDIV: begin
        if (!on_q[det_q]) begin
          wgt_we  = 1'b1;
          wgt_val = '0;
          det_d   = 1'b1;
          if (det_q) state_d = ST_EMIT;
        end else if (!started_q) begin
          div_start = 1'b1;
          started_d = 1'b1;
        end else if (div_sts.done) begin
          wgt_we    = 1'b1;
          started_d = 1'b0;
          det_d     = 1'b1;
          if (det_q) state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          det_d    = 1'b0;
          if (k_q == KLast) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + KW'(1);
            state_d = ST_WDIV;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      k_q         <= '0;
      det_q       <= 1'b0;
      power_q     <= PowReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      k_q       <= k_d;
      det_q     <= det_d;
      if (cfg_wr_en_i) power_q <= cfg_wr_data_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    pm_q   <= pm_d;
    sqv_q  <= sqv_d;
    e_q    <= e_d;
    dmin_q <= dmin_d;
    r_q    <= r_d;
    x_q    <= x_d;
    pcnt_q <= pcnt_d;
    if (in_acc) begin
      beta_q[0] <= s_axis_tdata_i[49:32];
      on_q[0]   <= s_axis_tdata_i[50];
      beta_q[1] <= s_axis_tdata_i[68:51];
      on_q[1]   <= s_axis_tdata_i[69];
    end
    if (bh_we) bh_q[k_q] <= div_quot[16:0];
    if (sum_clr) begin
      sum_q[det_q] <= '0;
    end else if (raw_we) begin
      sum_q[det_q] <= sum_q[det_q] + SUM_W'(x_q);
    end
    if (raw_we) raw_q[det_q][k_q] <= x_q;
    if (wgt_we) wgt_q[det_q] <= wgt_val;
    if (out_load) begin
      out_data_q <= {1'b0, on_q[1], wgt_q[1], on_q[0], wgt_q[0], hyp};
      out_last_q <= (k_q == KLast);
    end
  end

  tofw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqv_q),
    .root_o  (sqrt_root),
    .sts_o   (sqrt_sts)
  );

  tofw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quot_o     (div_quot),
    .sts_o      (div_sts)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tvalid_o = out_valid_q;

  `TOFW_ASSERT_IMP(a_div_start_idle, div_start, !div_sts.busy)
  `TOFW_ASSERT_IMP(a_sqrt_start_idle, sqrt_start, !sqrt_sts.busy)
  `TOFW_ASSERT_IMP(a_no_overwrite, out_load, !out_valid_q || m_axis_tready_i)
  `TOFW_ASSERT_IMP(a_last_hyp, m_axis_tvalid_o && m_axis_tlast_o,
                   m_axis_tdata_o[2:0] == 3'(KLast))

endmodule

`default_nettype wire
